FILE: rtl/core/tpbs_pkg.sv
// Package for the three-phase breath sequencer.
// Holds phase and mode codes, register indexes, reset values and the
// command and status structs shared by the controller and the datapath.
`default_nettype none

package tpbs_pkg;

  localparam int DUR_W    = 16;
  localparam int CNT_W    = 8;
  localparam int HR_W     = 8;
  localparam int TIME_W   = 32;
  localparam int PCT_W    = 7;
  localparam int REM_W    = 7;
  localparam int DELTA_W  = 9;
  localparam int IDX_W    = 3;
  localparam int IN_W     = 40;
  localparam int OUT_W    = 40;

  // The progress quotient stays below 128, so seven restoring steps are enough.
  localparam int DIV_STEPS = 7;
  localparam int STEP_W    = 3;
  localparam int NUM_W     = DUR_W + PCT_W;
  localparam int DSH_W     = DUR_W + DIV_STEPS - 1;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_INHALE = 2'd1;
  localparam logic [1:0] PH_HOLD   = 2'd2;
  localparam logic [1:0] PH_EXHALE = 2'd3;

  localparam logic [1:0] MODE_UPDATE = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_STOP   = 2'd2;

  localparam logic [IDX_W-1:0] CFG_INHALE   = 3'd0;
  localparam logic [IDX_W-1:0] CFG_HOLD     = 3'd1;
  localparam logic [IDX_W-1:0] CFG_EXHALE   = 3'd2;
  localparam logic [IDX_W-1:0] CFG_MAX_CYC  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_BASE_HR  = 3'd4;

  localparam logic [DUR_W-1:0] INHALE_RST  = 16'd4000;
  localparam logic [DUR_W-1:0] HOLD_RST    = 16'd7000;
  localparam logic [DUR_W-1:0] EXHALE_RST  = 16'd8000;
  localparam logic [CNT_W-1:0] MAX_CYC_RST = 8'd4;
  localparam logic [HR_W-1:0]  BASE_HR_RST = 8'd0;

  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
  localparam logic [DUR_W-1:0] MS_PER_S = 16'd1000;

  // Whole seconds come from a reciprocal multiply: x / 1000 = (x / 8) / 125.
  localparam int REM_PRE     = 3;
  localparam int REM_SHIFT   = 20;
  localparam int REM_DIVISOR = int'(MS_PER_S) >> REM_PRE;
  localparam int REM_RECIP   = ((1 << REM_SHIFT) + REM_DIVISOR - 1) / REM_DIVISOR;
  localparam int REM_PROD_W  = REM_SHIFT + REM_W;

  typedef struct packed {
    logic load_in;
    logic apply;
    logic setup;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/tpbs_ctrl.sv
// Controller state machine of the breath sequencer.
// Sequences apply, setup, divide and output load; owns the stream handshakes.
// Depends on tpbs_pkg.
`default_nettype none

module tpbs_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  input  wire tpbs_pkg::status_t sts,
  output tpbs_pkg::cmd_t        cmd
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_APPLY = 3'd1;
  localparam logic [2:0] ST_SETUP = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.load_in  = s_tvalid && s_tready;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_to_apply: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_APPLY)
    else $error("accepted item did not start the apply step");
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> out_free)
    else $error("output register overwritten while holding an item");
  a_div_exit: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && sts.div_last |=> state == ST_OUT)
    else $error("divider finished but controller did not move to output");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/tpbs_datapath.sv
// Datapath of the breath sequencer: configuration and session registers,
// elapsed time, a seven-step restoring divider for the progress, a reciprocal
// multiply for the seconds and the output register. Depends on tpbs_pkg.
`default_nettype none

module tpbs_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tpbs_pkg::cmd_t                cmd,
  output tpbs_pkg::status_t                  sts,
  input  wire logic [1:0]                    in_mode,
  input  wire logic [tpbs_pkg::IN_W-1:0]     in_data,
  input  wire logic                          cfg_we,
  input  wire logic [tpbs_pkg::IDX_W-1:0]    cfg_index,
  input  wire logic [tpbs_pkg::DUR_W-1:0]    cfg_data,
  output logic [tpbs_pkg::OUT_W-1:0]         out_data
);

  // Configuration registers.
  logic [tpbs_pkg::DUR_W-1:0] inhale_ms;
  logic [tpbs_pkg::DUR_W-1:0] hold_ms;
  logic [tpbs_pkg::DUR_W-1:0] exhale_ms;
  logic [tpbs_pkg::CNT_W-1:0] max_cycles;
  logic [tpbs_pkg::HR_W-1:0]  baseline_hr;

  // Session state.
  logic [1:0]                  cur_phase;
  logic [tpbs_pkg::TIME_W-1:0] phase_start;
  logic                        running;
  logic [tpbs_pkg::CNT_W-1:0]  cycle_count;
  logic                        done_flag;
  logic [tpbs_pkg::HR_W-1:0]   end_hr;

  logic [1:0]                  cur_phase_next;
  logic [tpbs_pkg::TIME_W-1:0] phase_start_next;
  logic                        running_next;
  logic [tpbs_pkg::CNT_W-1:0]  cycle_count_next;
  logic                        done_flag_next;

  // Captured item.
  logic [1:0]                  mode;
  logic [tpbs_pkg::TIME_W-1:0] now_ms;
  logic [tpbs_pkg::HR_W-1:0]   heart_rate;

  // Divider and result staging.
  logic                        show;
  logic                        full;
  logic [tpbs_pkg::NUM_W-1:0]  pct_num;
  logic [tpbs_pkg::DSH_W-1:0]  pct_div;
  logic [tpbs_pkg::PCT_W-1:0]  pct_q;
  logic [tpbs_pkg::DUR_W-1:0]  rem_num;
  logic [tpbs_pkg::REM_PROD_W-1:0] rem_prod;
  logic [tpbs_pkg::REM_W-1:0]  rem_q;
  logic [tpbs_pkg::STEP_W-1:0] step;

  logic [tpbs_pkg::TIME_W-1:0] elapsed;
  logic [tpbs_pkg::DUR_W-1:0]  dur;
  logic                        expired;
  logic [tpbs_pkg::DUR_W-1:0]  el16;
  logic                        pct_ge;
  logic [tpbs_pkg::PCT_W-1:0]  pct_out;
  logic [tpbs_pkg::REM_W-1:0]  rem_out;
  logic [tpbs_pkg::DELTA_W-1:0] delta;

  always_comb begin
    case (cur_phase)
      tpbs_pkg::PH_INHALE: dur = inhale_ms;
      tpbs_pkg::PH_HOLD:   dur = hold_ms;
      tpbs_pkg::PH_EXHALE: dur = exhale_ms;
      default:             dur = '0;
    endcase
  end

  assign elapsed = now_ms - phase_start;
  assign expired = elapsed >= tpbs_pkg::TIME_W'(dur);
  assign el16    = elapsed[tpbs_pkg::DUR_W-1:0];

  always_comb begin
    cur_phase_next   = cur_phase;
    phase_start_next = phase_start;
    running_next     = running;
    cycle_count_next = cycle_count;
    done_flag_next   = done_flag;
    case (mode)
      tpbs_pkg::MODE_START: begin
        running_next     = 1'b1;
        phase_start_next = now_ms;
        cur_phase_next   = tpbs_pkg::PH_INHALE;
        cycle_count_next = '0;
        done_flag_next   = 1'b0;
      end
      tpbs_pkg::MODE_STOP: begin
        running_next   = 1'b0;
        cur_phase_next = tpbs_pkg::PH_IDLE;
      end
      tpbs_pkg::MODE_UPDATE: begin
        if (running && expired) begin
          case (cur_phase)
            tpbs_pkg::PH_INHALE: begin
              cur_phase_next   = tpbs_pkg::PH_HOLD;
              phase_start_next = now_ms;
            end
            tpbs_pkg::PH_HOLD: begin
              cur_phase_next   = tpbs_pkg::PH_EXHALE;
              phase_start_next = now_ms;
            end
            tpbs_pkg::PH_EXHALE: begin
              cycle_count_next = cycle_count + 1'b1;
              if (cycle_count_next >= max_cycles) begin
                done_flag_next = 1'b1;
                running_next   = 1'b0;
                cur_phase_next = tpbs_pkg::PH_IDLE;
              end else begin
                cur_phase_next   = tpbs_pkg::PH_INHALE;
                phase_start_next = now_ms;
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inhale_ms   <= tpbs_pkg::INHALE_RST;
      hold_ms     <= tpbs_pkg::HOLD_RST;
      exhale_ms   <= tpbs_pkg::EXHALE_RST;
      max_cycles  <= tpbs_pkg::MAX_CYC_RST;
      baseline_hr <= tpbs_pkg::BASE_HR_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tpbs_pkg::CFG_INHALE:  inhale_ms   <= cfg_data;
        tpbs_pkg::CFG_HOLD:    hold_ms     <= cfg_data;
        tpbs_pkg::CFG_EXHALE:  exhale_ms   <= cfg_data;
        tpbs_pkg::CFG_MAX_CYC: max_cycles  <= cfg_data[tpbs_pkg::CNT_W-1:0];
        tpbs_pkg::CFG_BASE_HR: baseline_hr <= cfg_data[tpbs_pkg::HR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_phase   <= tpbs_pkg::PH_IDLE;
      phase_start <= '0;
      running     <= 1'b0;
      cycle_count <= '0;
      done_flag   <= 1'b0;
      end_hr      <= '0;
    end else if (cmd.apply) begin
      cur_phase   <= cur_phase_next;
      phase_start <= phase_start_next;
      running     <= running_next;
      cycle_count <= cycle_count_next;
      done_flag   <= done_flag_next;
      if (mode == tpbs_pkg::MODE_STOP) end_hr <= heart_rate;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      mode       <= in_mode;
      now_ms     <= in_data[tpbs_pkg::TIME_W-1:0];
      heart_rate <= in_data[tpbs_pkg::TIME_W +: tpbs_pkg::HR_W];
    end
  end

  assign pct_ge = pct_num >= tpbs_pkg::NUM_W'(pct_div);
  assign sts.div_last = (step == '0);

  assign rem_prod = tpbs_pkg::REM_PROD_W'(rem_num >> tpbs_pkg::REM_PRE) *
                    tpbs_pkg::REM_PROD_W'(tpbs_pkg::REM_RECIP);
  assign rem_q    = rem_prod[tpbs_pkg::REM_SHIFT +: tpbs_pkg::REM_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (cmd.setup) begin
      step <= tpbs_pkg::STEP_W'(tpbs_pkg::DIV_STEPS - 1);
    end else if (cmd.div_step && step != '0) begin
      step <= step - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      show    <= running && (cur_phase != tpbs_pkg::PH_IDLE);
      full    <= expired;
      pct_num <= tpbs_pkg::NUM_W'(el16) * tpbs_pkg::NUM_W'(tpbs_pkg::PCT_FULL);
      pct_div <= {dur, {(tpbs_pkg::DIV_STEPS-1){1'b0}}};
      pct_q   <= '0;
      rem_num <= dur - el16;
    end else if (cmd.div_step) begin
      if (pct_ge) pct_num <= pct_num - tpbs_pkg::NUM_W'(pct_div);
      pct_q   <= {pct_q[tpbs_pkg::PCT_W-2:0], pct_ge};
      pct_div <= pct_div >> 1;
    end
  end

  always_comb begin
    pct_out = '0;
    rem_out = '0;
    if (show) begin
      if (full) begin
        pct_out = tpbs_pkg::PCT_FULL;
      end else begin
        pct_out = pct_q;
        rem_out = rem_q;
      end
    end
  end

  assign delta = (end_hr != '0 && baseline_hr != '0) ?
                 (tpbs_pkg::DELTA_W'(end_hr) - tpbs_pkg::DELTA_W'(baseline_hr)) : '0;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data <= {5'b0, delta, rem_out, pct_out, done_flag, running, cycle_count,
                   cur_phase};
    end
  end

`ifndef NO_ASSERTIONS
  a_run_phase: assert property (@(posedge clk) disable iff (rst)
    running == (cur_phase != tpbs_pkg::PH_IDLE))
    else $error("running flag and phase disagree");
  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out && show && !full |-> pct_q < tpbs_pkg::PCT_FULL)
    else $error("progress quotient out of range");
  a_div_count: assert property (@(posedge clk) disable iff (rst)
    cmd.setup |=> step == tpbs_pkg::STEP_W'(tpbs_pkg::DIV_STEPS - 1))
    else $error("divider step count not loaded");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/three_phase_breath_sequencer_unit.sv
// The seven-step restoring divider forms the progress percentage, and the
// seconds come from a multiply beside it. An item is accepted only in idle,
// after the previous item has been loaded into the output register.
// A new item is taken while the previous result still waits on the output.
// Reset (rst, synchronous, active high) returns the configuration registers to
// their defaults and the session to idle.
`default_nettype none

module three_phase_breath_sequencer_unit (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [tpbs_pkg::IN_W-1:0]  s_tdata,  // now_ms[31:0], heart_rate[39:32]
  input  wire logic [1:0]                 s_tuser,  // mode[1:0]
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  // phase[1:0], cycles_done[9:2], active[10], finished[11],
  // progress_pct[18:12], remaining_s[25:19], hr_delta[34:26]
  output logic [tpbs_pkg::OUT_W-1:0]      m_tdata,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [tpbs_pkg::IDX_W-1:0] cfg_index,
  input  wire logic [tpbs_pkg::DUR_W-1:0] cfg_data
);

  tpbs_pkg::cmd_t    cmd;
  tpbs_pkg::status_t sts;

  assign cfg_ready = 1'b1;

  tpbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpbs_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_mode   (s_tuser),
    .in_data   (s_tdata),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (m_tdata)
  );

endmodule

`default_nettype wire
